// ===== sv/ppe_pkg.sv =====
// Shared types, constants and fixed-point helpers for the particle pool.
// Used by every module of particle_pool_euler_step but ppe_ram; depends on nothing.
package ppe_pkg;

    localparam int POOL_DEPTH_DEF = 1024;
    localparam int IN_W  = 320;
    localparam int OUT_W = 304;

    localparam logic signed [31:0] GRAVITY_RST = -32'sd642253;
    localparam logic [10:0]        LIMIT_RST   = 11'd1000;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_SPAWN = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOT_LIVE = 2'd2;

    localparam logic REG_GRAVITY = 1'b0;
    localparam logic REG_LIMIT   = 1'b1;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic [30:0]        age;
        logic [30:0]        life;
        logic signed [31:0] angle;
        logic signed [31:0] spin;
    } t_rec;

    typedef struct packed {
        logic cap;
        logic gdt;
        logic expire;
        logic load;
        logic mul;
        logic adv;
        logic spawn;
        logic rd;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       expired;
        logic       more;
        logic       empty;
        logic       out_free;
    } t_sts;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) begin
            sat_add = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            sat_add = s[31:0];
        end
    endfunction

    // Product with dt, shifted down by 16 and rounded toward minus infinity.
    function automatic logic signed [31:0] mul_dt(input logic signed [31:0] a,
                                                  input logic [15:0] dt);
        logic signed [48:0] p;
        p = a * $signed({1'b0, dt});
        mul_dt = p[47:16];
    endfunction

endpackage

// ===== sv/ppe_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module ppe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/ppe_ctrl.sv =====
// Sequencer of the particle pool: decodes an item and steps the datapath.
// Depends on ppe_pkg.
module ppe_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_tvalid,
    output logic          o_tready,
    input  ppe_pkg::t_sts i_sts,
    output ppe_pkg::t_cmd o_cmd
);
    import ppe_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_EVAL   = 3'd2;
    localparam logic [2:0] S_MUL    = 3'd3;
    localparam logic [2:0] S_ADD    = 3'd4;
    localparam logic [2:0] S_RDW    = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_tvalid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.kind)
                    KIND_TICK: begin
                        o_cmd.gdt = 1'b1;
                        n_state   = i_sts.empty ? S_FIN : S_EVAL;
                    end
                    KIND_SPAWN: begin
                        o_cmd.spawn = 1'b1;
                        n_state     = S_FIN;
                    end
                    KIND_READ: begin
                        o_cmd.rd = 1'b1;
                        n_state  = S_RDW;
                    end
                    default: n_state = S_FIN;
                endcase
            end
            S_EVAL: begin
                if (i_sts.expired) begin
                    o_cmd.expire = 1'b1;
                    n_state      = i_sts.more ? S_EVAL : S_FIN;
                end else begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.adv = 1'b1;
                n_state   = i_sts.more ? S_EVAL : S_FIN;
            end
            S_RDW: n_state = S_FIN;
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_tready = (r_state == S_IDLE);
endmodule

// ===== sv/ppe_dp.sv =====
// Datapath of the particle pool: particle RAM, counters, four multiply lanes,
// saturating adders and the result register. Depends on ppe_pkg and ppe_ram.
module ppe_dp #(
    parameter int POOL_DEPTH = ppe_pkg::POOL_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ppe_pkg::t_cmd              i_cmd,
    output ppe_pkg::t_sts              o_sts,
    input  logic [ppe_pkg::IN_W-1:0]   i_tdata,
    input  logic [1:0]                 i_tuser,
    input  logic signed [31:0]         i_gravity,
    input  logic [10:0]                i_pool_limit,
    output logic                       o_tvalid,
    input  logic                       i_tready,
    output logic [ppe_pkg::OUT_W-1:0]  o_tdata
);
    import ppe_pkg::*;

    localparam int AW = $clog2(POOL_DEPTH);
    localparam int CW = $clog2(POOL_DEPTH + 1);
    localparam int LW = (CW > 11) ? CW : 11;
    localparam int RW = $bits(t_rec);

    logic [1:0]         r_kind;
    logic [15:0]        r_dt;
    logic [9:0]         r_slot;
    t_rec               r_spawn;
    logic [1:0]         r_st;
    logic [CW-1:0]      r_live;
    logic [AW-1:0]      r_idx;
    logic signed [31:0] r_gdt;
    t_rec               r_cur;
    t_rec               n_cur;
    logic signed [31:0] r_prod [4];
    logic               r_ovalid;
    logic [OUT_W-1:0]   r_odata;
    logic [OUT_W-1:0]   n_odata;

    t_rec               rdata;
    logic [RW-1:0]      rdata_raw;
    logic               we, re;
    logic [AW-1:0]      waddr, raddr;
    t_rec               wrec, trec;
    logic [31:0]        age_sum;
    logic [30:0]        age_new;
    logic signed [31:0] vy_new;
    logic signed [31:0] lane1;
    logic [CW-1:0]      idx1, live_m1;
    logic [LW-1:0]      lim, depth_w, limit_w, slot_w, live_w;
    logic               full, bad;

    assign rdata   = t_rec'(rdata_raw);
    assign age_sum = {1'b0, rdata.age} + {16'd0, r_dt};
    assign age_new = age_sum[31] ? 31'h7fff_ffff : age_sum[30:0];
    assign vy_new  = sat_add(rdata.vel_y, r_gdt);
    assign lane1   = mul_dt(i_cmd.gdt ? i_gravity : r_cur.vel_y, r_dt);

    assign idx1    = CW'(r_idx) + CW'(1);
    assign live_m1 = r_live - CW'(1);
    assign depth_w = LW'(POOL_DEPTH);
    assign limit_w = LW'(i_pool_limit);
    assign lim     = (limit_w < depth_w) ? limit_w : depth_w;
    assign live_w  = LW'(r_live);
    assign slot_w  = LW'(r_slot);
    assign full    = live_w >= lim;
    assign bad     = (slot_w >= live_w) || (slot_w >= depth_w);

    always_comb begin
        trec       = r_cur;
        trec.pos_x = sat_add(r_cur.pos_x, r_prod[0]);
        trec.pos_y = sat_add(r_cur.pos_y, r_prod[1]);
        trec.pos_z = sat_add(r_cur.pos_z, r_prod[2]);
        trec.angle = sat_add(r_cur.angle, r_prod[3]);
    end

    // Working record as loaded: aged, with gravity already applied.
    always_comb begin
        n_cur       = rdata;
        n_cur.age   = age_new;
        n_cur.vel_y = vy_new;
    end

    // Result word: data fields only for a read of a live slot.
    always_comb begin
        n_odata        = '0;
        n_odata[1:0]   = r_st;
        n_odata[12:2]  = 11'(r_live);
        if (r_kind == KIND_READ && r_st == ST_OK) begin
            n_odata[44:13]   = rdata.pos_x;
            n_odata[76:45]   = rdata.pos_y;
            n_odata[108:77]  = rdata.pos_z;
            n_odata[140:109] = rdata.vel_x;
            n_odata[172:141] = rdata.vel_y;
            n_odata[204:173] = rdata.vel_z;
            n_odata[235:205] = rdata.age;
            n_odata[266:236] = rdata.life;
            n_odata[298:267] = rdata.angle;
        end
    end

    always_comb begin
        we    = i_cmd.adv || (i_cmd.spawn && !full);
        waddr = i_cmd.spawn ? r_live[AW-1:0] : r_idx;
        wrec  = i_cmd.spawn ? r_spawn : trec;
        re    = i_cmd.gdt || i_cmd.expire || i_cmd.adv || i_cmd.rd;
        raddr = '0;
        if (i_cmd.expire) begin
            raddr = live_m1[AW-1:0];
        end else if (i_cmd.adv) begin
            raddr = idx1[AW-1:0];
        end else if (i_cmd.rd) begin
            raddr = slot_w[AW-1:0];
        end
    end

    ppe_ram #(.WIDTH(RW), .DEPTH(POOL_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wrec),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata_raw)
    );

    // Item capture, status, gravity product, lane products, the working record and the result word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_kind        <= i_tuser;
            r_dt          <= i_tdata[15:0];
            r_slot        <= i_tdata[25:16];
            r_spawn.pos_x <= i_tdata[57:26];
            r_spawn.pos_y <= i_tdata[89:58];
            r_spawn.pos_z <= i_tdata[121:90];
            r_spawn.vel_x <= i_tdata[153:122];
            r_spawn.vel_y <= i_tdata[185:154];
            r_spawn.vel_z <= i_tdata[217:186];
            r_spawn.life  <= i_tdata[248:218];
            r_spawn.age   <= '0;
            r_spawn.angle <= i_tdata[280:249];
            r_spawn.spin  <= i_tdata[312:281];
            r_st          <= ST_OK;
        end
        if (i_cmd.spawn) begin
            r_st <= full ? ST_FULL : ST_OK;
        end
        if (i_cmd.rd) begin
            r_st <= bad ? ST_NOT_LIVE : ST_OK;
        end
        if (i_cmd.gdt) begin
            r_gdt <= lane1;
        end
        if (i_cmd.load) begin
            r_cur <= n_cur;
        end
        if (i_cmd.mul) begin
            r_prod[0] <= mul_dt(r_cur.vel_x, r_dt);
            r_prod[1] <= lane1;
            r_prod[2] <= mul_dt(r_cur.vel_z, r_dt);
            r_prod[3] <= mul_dt(r_cur.spin, r_dt);
        end
        if (i_cmd.fin) begin
            r_odata <= n_odata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live   <= '0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.gdt) begin
                r_idx <= '0;
            end
            if (i_cmd.expire) begin
                r_live <= live_m1;
            end
            if (i_cmd.adv) begin
                r_idx <= idx1[AW-1:0];
            end
            if (i_cmd.spawn && !full) begin
                r_live <= r_live + CW'(1);
            end
            if (i_cmd.fin) begin
                r_ovalid <= 1'b1;
            end else if (i_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts          = '0;
        o_sts.kind     = r_kind;
        o_sts.expired  = age_new >= rdata.life;
        o_sts.more     = idx1 < r_live;
        o_sts.empty    = (r_live == '0);
        o_sts.out_free = !r_ovalid || i_tready;
    end

    assign o_tvalid = r_ovalid;
    assign o_tdata  = r_odata;
endmodule

// ===== sv/particle_pool_euler_step.sv =====
// Top level of the Euler particle pool: stream ports, APB registers,
// sequencer and datapath. Depends on ppe_pkg, ppe_ctrl, ppe_dp and ppe_ram.
//
//   Channel   Direction  Carries
//   s_axis    in         one item: kind in tuser, dt/slot/spawn values in tdata
//   m_axis    out        one result per item: status, live count, slot data
//   APB       in/out     gravity at 0x0, pool_limit at 0x4
//
// A spawn passes decode and the final step; a read also waits on the RAM's
// registered read. A tick takes each surviving particle through evaluate,
// multiply and add, and each expiring one through evaluate alone; the pace is set
// by the RAM's single read port and the register stage after the four multiply lanes.
// Reset clears the live count, the walk index, the sequencer and the result
// valid, and returns both registers to their defaults; the particle RAM is
// left as it is, since data read from slots that are not live is never used.
// A stalled result holds the sequencer in its final step; the next item is
// still taken while a previous result waits.
module particle_pool_euler_step #(
    parameter int POOL_DEPTH = ppe_pkg::POOL_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // s_axis
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // tdata from bit 0: dt[15:0], slot[25:16], pos_x, pos_y, pos_z, vel_x,
    // vel_y, vel_z (32 bits each, from bit 26), lifetime[248:218],
    // angle[280:249], spin[312:281], zero padding
    input  logic [ppe_pkg::IN_W-1:0]  s_axis_tdata,
    // tuser: kind[1:0]
    input  logic [1:0]                s_axis_tuser,
    // m_axis
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // tdata from bit 0: status[1:0], live_total[12:2], out_pos_x, out_pos_y,
    // out_pos_z, out_vel_x, out_vel_y, out_vel_z (32 bits each, from bit 13),
    // out_age[235:205], out_lifetime[266:236], out_angle[298:267], padding
    output logic [ppe_pkg::OUT_W-1:0] m_axis_tdata,
    // APB
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import ppe_pkg::*;

    logic signed [31:0] r_gravity;
    logic [10:0]        r_pool_limit;
    logic               wr_en;
    t_cmd               cmd;
    t_sts               sts;

    // Registers are decoded on address bit 2 only.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity    <= GRAVITY_RST;
            r_pool_limit <= LIMIT_RST;
        end else if (wr_en) begin
            case (paddr[2])
                REG_GRAVITY: r_gravity    <= pwdata;
                REG_LIMIT:   r_pool_limit <= pwdata[10:0];
                default:     r_gravity    <= r_gravity;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_GRAVITY: prdata = r_gravity;
            REG_LIMIT:   prdata = {21'd0, r_pool_limit};
            default:     prdata = '0;
        endcase
    end

    ppe_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_sts    (sts),
        .o_cmd    (cmd)
    );

    ppe_dp #(.POOL_DEPTH(POOL_DEPTH)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_tdata      (s_axis_tdata),
        .i_tuser      (s_axis_tuser),
        .i_gravity    (r_gravity),
        .i_pool_limit (r_pool_limit),
        .o_tvalid     (m_axis_tvalid),
        .i_tready     (m_axis_tready),
        .o_tdata      (m_axis_tdata)
    );
endmodule

// ===== sv/ppe_chk.sv =====
// Port-level checks of particle_pool_euler_step and the bind that attaches them.
// Depends on ppe_pkg.
module ppe_chk #(
    parameter int POOL_DEPTH = ppe_pkg::POOL_DEPTH_DEF
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      s_axis_tvalid,
    input logic                      s_axis_tready,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [ppe_pkg::OUT_W-1:0] m_axis_tdata
);
    import ppe_pkg::*;

    a_rst_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
        else $error("unused status code");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] == ST_FULL || m_axis_tdata[1:0] == ST_NOT_LIVE)
        |-> m_axis_tdata[298:13] == '0)
        else $error("data on a refused item");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken while busy");
endmodule

bind particle_pool_euler_step ppe_chk #(.POOL_DEPTH(POOL_DEPTH)) u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/sv/particle_pool_euler_step_tb.sv =====
// Self-checking testbench for particle_pool_euler_step: stream items in,
// results out, predicted by an in-bench copy of the particle pool.
// Depends on ppe_pkg and the particle_pool_euler_step RTL.
module particle_pool_euler_step_tb;
    import ppe_pkg::*;

    localparam int DEPTH     = 1024;
    localparam int STALL_MAX = 20000;
    localparam logic [2:0] ADDR_GRAVITY = 3'd0;
    localparam logic [2:0] ADDR_LIMIT   = 3'd4;

    typedef struct {
        logic [1:0]         kind;
        logic [15:0]        dt;
        logic [9:0]         slot;
        logic signed [31:0] pos [3];
        logic signed [31:0] vel [3];
        logic [30:0]        life;
        logic signed [31:0] angle;
        logic signed [31:0] spin;
    } t_pool_item;

    typedef struct {
        logic signed [31:0] pos [3];
        logic signed [31:0] vel [3];
        logic [30:0]        age;
        logic [30:0]        life;
        logic signed [31:0] angle;
        logic signed [31:0] spin;
    } t_shadow_slot;

    typedef struct {
        logic [1:0]         status;
        logic [10:0]        live;
        logic signed [31:0] pos [3];
        logic signed [31:0] vel [3];
        logic [30:0]        age;
        logic [30:0]        life;
        logic signed [31:0] angle;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic [1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    particle_pool_euler_step dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow of the block: particle slots, live count and the two registers.
    t_shadow_slot       pool [DEPTH];
    int unsigned        live_n = 0;
    logic signed [31:0] grav = GRAVITY_RST;
    logic [10:0]        limit = LIMIT_RST;

    t_pool_item pending_items [$];
    t_pool_item cur_item;
    t_answer    awaited [$];
    int         fail_cnt = 0;

    // Q16.16 times Q0.16, floored; the arithmetic shift of a 64-bit product floors.
    function automatic longint scale_dt(logic signed [31:0] a, logic [15:0] dt);
        longint p;
        p = longint'(a) * longint'({1'b0, dt});
        return p >>> 16;
    endfunction

    function automatic logic signed [31:0] clamp_add(logic signed [31:0] a, longint b);
        longint s;
        s = longint'(a) + b;
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        return s[31:0];
    endfunction

    function automatic logic [IN_W-1:0] pack_item(t_pool_item it);
        logic [IN_W-1:0] d;
        d = '0;
        d[15:0]    = it.dt;
        d[25:16]   = it.slot;
        for (int k = 0; k < 3; k++) begin
            d[26 + 32*k +: 32] = it.pos[k];
            d[122 + 32*k +: 32] = it.vel[k];
        end
        d[248:218] = it.life;
        d[280:249] = it.angle;
        d[312:281] = it.spin;
        return d;
    endfunction

    // Advance the shadow pool by one item and queue the answer it should give.
    task automatic advance_pool(t_pool_item it);
        t_answer     r;
        int unsigned n, i, lim;
        longint      a;
        r.status = ST_OK;
        for (int k = 0; k < 3; k++) begin
            r.pos[k] = '0;
            r.vel[k] = '0;
        end
        r.age = '0;
        r.life = '0;
        r.angle = '0;
        case (it.kind)
            KIND_TICK: begin
                n = live_n;
                i = 0;
                while (i < n) begin
                    a = longint'(pool[i].age) + longint'(it.dt);
                    if (a > 64'sd2147483647) a = 64'sd2147483647;
                    pool[i].age = a[30:0];
                    if (a >= longint'(pool[i].life)) begin
                        // Expired: the last live particle takes this slot and is
                        // handled here on the next pass of the loop.
                        pool[i] = pool[n-1];
                        n--;
                    end else begin
                        pool[i].vel[1] = clamp_add(pool[i].vel[1], scale_dt(grav, it.dt));
                        for (int k = 0; k < 3; k++)
                            pool[i].pos[k] = clamp_add(pool[i].pos[k],
                                                       scale_dt(pool[i].vel[k], it.dt));
                        pool[i].angle = clamp_add(pool[i].angle,
                                                  scale_dt(pool[i].spin, it.dt));
                        i++;
                    end
                end
                live_n = n;
            end
            KIND_SPAWN: begin
                lim = (limit < DEPTH) ? limit : DEPTH;
                if (live_n >= lim) begin
                    r.status = ST_FULL;
                end else begin
                    pool[live_n].pos = it.pos;
                    pool[live_n].vel = it.vel;
                    pool[live_n].age = '0;
                    pool[live_n].life = it.life;
                    pool[live_n].angle = it.angle;
                    pool[live_n].spin = it.spin;
                    live_n++;
                end
            end
            KIND_READ: begin
                if (it.slot >= live_n) begin
                    r.status = ST_NOT_LIVE;
                end else begin
                    r.pos = pool[it.slot].pos;
                    r.vel = pool[it.slot].vel;
                    r.age = pool[it.slot].age;
                    r.life = pool[it.slot].life;
                    r.angle = pool[it.slot].angle;
                end
            end
            default: ;
        endcase
        r.live = live_n[10:0];
        awaited.push_back(r);
    endtask

    // Sender: bursts of random length separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) advance_pool(cur_item);
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                cur_item = pending_items.pop_front();
                s_axis_tdata <= pack_item(cur_item);
                s_axis_tuser <= cur_item.kind;
                s_axis_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: the stall pattern switches between four randomly drawn modes.
    int rx_cyc = 0;
    int rx_mode = 0;
    always @(posedge i_clk) begin
        rx_cyc <= rx_cyc + 1;
        if (rx_cyc % 64 == 0) rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 1) == 1);
            2: m_axis_tready <= (rx_cyc % 16) > 11;
            default: m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_cnt++;
        end
    endtask

    // Monitor: every accepted result against the oldest answer waiting.
    always @(posedge i_clk) begin
        t_answer r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (awaited.size() == 0) begin
                $error("result with nothing awaited: %h", m_axis_tdata);
                fail_cnt++;
            end else begin
                r = awaited.pop_front();
                check_field("status", r.status, m_axis_tdata[1:0]);
                check_field("live_total", r.live, m_axis_tdata[12:2]);
                check_field("out_pos_x", r.pos[0], m_axis_tdata[44:13]);
                check_field("out_pos_y", r.pos[1], m_axis_tdata[76:45]);
                check_field("out_pos_z", r.pos[2], m_axis_tdata[108:77]);
                check_field("out_vel_x", r.vel[0], m_axis_tdata[140:109]);
                check_field("out_vel_y", r.vel[1], m_axis_tdata[172:141]);
                check_field("out_vel_z", r.vel[2], m_axis_tdata[204:173]);
                check_field("out_age", r.age, m_axis_tdata[235:205]);
                check_field("out_lifetime", r.life, m_axis_tdata[266:236]);
                check_field("out_angle", r.angle, m_axis_tdata[298:267]);
            end
        end
    end

    // Watchdog on cycles in which neither side moves an item.
    int quiet_cyc = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cyc <= 0;
        else
            quiet_cyc <= quiet_cyc + 1;
        if (quiet_cyc > STALL_MAX) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_regs(logic signed [31:0] g, logic [10:0] l);
        apb_write(ADDR_GRAVITY, g);
        apb_write(ADDR_LIMIT, {21'd0, l});
        grav = g;
        limit = l;
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || awaited.size() > 0 || s_axis_tvalid)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic t_pool_item blank_item(logic [1:0] kind);
        t_pool_item it;
        it.kind = kind;
        it.dt = '0;
        it.slot = '0;
        for (int k = 0; k < 3; k++) begin
            it.pos[k] = '0;
            it.vel[k] = '0;
        end
        it.life = '0;
        it.angle = '0;
        it.spin = '0;
        return it;
    endfunction

    function automatic logic [31:0] rand_q16();
        case ($urandom_range(0, 5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2, 3: return $urandom;
            default: return $signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000;
        endcase
    endfunction

    // Random item: mostly spawns, ticks and reads of low slots, with short lifetimes
    // so that particles expire; now and then the unused kind and far slots.
    function automatic t_pool_item rand_item();
        t_pool_item it;
        int w;
        w = $urandom_range(0, 99);
        it = blank_item(w < 38 ? KIND_SPAWN : w < 62 ? KIND_TICK : w < 96 ? KIND_READ : 2'd3);
        case ($urandom_range(0, 4))
            0: it.dt = 16'hffff;
            1: it.dt = $urandom_range(0, 15);
            default: it.dt = $urandom;
        endcase
        it.slot = ($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'($urandom_range(0, 17));
        for (int k = 0; k < 3; k++) begin
            it.pos[k] = rand_q16();
            it.vel[k] = rand_q16();
        end
        it.life = ($urandom_range(0, 5) == 0) ? 31'($urandom) : 31'($urandom_range(0, 32'h4_0000));
        it.angle = rand_q16();
        it.spin = rand_q16();
        return it;
    endfunction

    task automatic random_phase(int count);
        repeat (count) pending_items.push_back(rand_item());
        drain();
    endtask

    initial begin
        t_pool_item it;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset register values.
        pending_items.push_back(blank_item(KIND_READ));
        pending_items.push_back(blank_item(KIND_TICK));
        pending_items.push_back(blank_item(2'd3));
        it = blank_item(KIND_SPAWN);
        for (int k = 0; k < 3; k++) begin
            it.pos[k] = 32'h7fff_ffff;
            it.vel[k] = 32'h7fff_ffff;
        end
        it.life = 31'h7fff_ffff;
        it.angle = 32'h7fff_ffff;
        it.spin = 32'h7fff_ffff;
        pending_items.push_back(it);
        for (int k = 0; k < 3; k++) begin
            it.pos[k] = 32'h8000_0000;
            it.vel[k] = 32'h8000_0000;
        end
        it.angle = 32'h8000_0000;
        it.spin = 32'h8000_0000;
        pending_items.push_back(it);
        // Zero lifetime: expires at the very next tick, even one of zero dt.
        it = blank_item(KIND_SPAWN);
        it.pos[0] = 32'sh0001_0000;
        pending_items.push_back(it);
        it.life = 31'h0002_0000;
        it.vel[1] = 32'sh0003_8000;
        it.spin = -32'sh0000_4000;
        pending_items.push_back(it);
        for (int s = 0; s < 4; s++) begin
            it = blank_item(KIND_READ);
            it.slot = s;
            pending_items.push_back(it);
        end
        it = blank_item(KIND_READ);
        it.slot = 10'h3ff;
        pending_items.push_back(it);
        it = blank_item(KIND_TICK);
        pending_items.push_back(it);
        it.dt = 16'hffff;
        pending_items.push_back(it);
        pending_items.push_back(it);
        for (int s = 0; s < 4; s++) begin
            it = blank_item(KIND_READ);
            it.slot = s;
            pending_items.push_back(it);
        end
        drain();

        // Largest gravity and the smallest limit: a spawn is dropped while a particle is live.
        set_regs(32'sh7fff_ffff, 11'd1);
        random_phase(90);

        // Smallest gravity, limit of four.
        set_regs(32'sh8000_0000, 11'd4);
        random_phase(90);

        // Fill to eight, then lower the limit under the live count.
        set_regs(GRAVITY_RST, 11'd8);
        repeat (8) begin
            it = rand_item();
            it.kind = KIND_SPAWN;
            it.life = 31'h7fff_0000;
            pending_items.push_back(it);
        end
        drain();
        set_regs(GRAVITY_RST, 11'd2);
        random_phase(80);

        // Full depth as the limit.
        set_regs($urandom, 11'd1024);
        random_phase(100);

        repeat (3) begin
            set_regs($urandom, 11'($urandom_range(1, 16)));
            random_phase(75);
        end

        if (fail_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== particle_pool_euler_step.f =====
sv/ppe_pkg.sv
sv/ppe_ram.sv
sv/ppe_ctrl.sv
sv/ppe_dp.sv
sv/particle_pool_euler_step.sv
sv/ppe_chk.sv
tb/sv/particle_pool_euler_step_tb.sv
